FILE: rtl/ecgos_pkg.sv
// Package for the Euler central-gravity orbit step core.
// Holds the payload structs, state codes, constants and helpers.
// Depends on nothing; every other file of the core uses it.
`timescale 1ns / 1ps

package ecgos_pkg;

    localparam int WORD_BITS = 56;
    localparam int FRAC_BITS = 32;
    localparam int MAG_BITS  = 64;
    localparam int REG_BITS  = 55;
    localparam int IDX_BITS  = 2;

    localparam logic [MAG_BITS-1:0] VEL_SCALE =
        (64'd365 << FRAC_BITS) + (((64'd242 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [REG_BITS-1:0] G_RESET   = 55'(64'd43000 << FRAC_BITS);
    localparam logic [MAG_BITS-1:0] HALF_WORD = 64'd1 << (WORD_BITS - 1);

    localparam logic [IDX_BITS-1:0] REG_GRAVITY = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_STEP    = 2'd1;
    localparam logic ACT_LOAD = 1'b0;

    typedef struct packed {
        logic                        action;
        logic signed [WORD_BITS-1:0] init_pos_x;
        logic signed [WORD_BITS-1:0] init_pos_y;
        logic signed [WORD_BITS-1:0] init_pos_z;
        logic signed [WORD_BITS-1:0] init_vel_x;
        logic signed [WORD_BITS-1:0] init_vel_y;
        logic signed [WORD_BITS-1:0] init_vel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] pos_x;
        logic signed [WORD_BITS-1:0] pos_y;
        logic signed [WORD_BITS-1:0] pos_z;
        logic signed [WORD_BITS-1:0] vel_x;
        logic signed [WORD_BITS-1:0] vel_y;
        logic signed [WORD_BITS-1:0] vel_z;
        logic                        at_origin;
        logic                        saturated;
    } out_item_t;

    typedef struct packed {
        logic                 sat;
        logic [WORD_BITS-1:0] word;
    } word_sat_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LD_MUL, S_LD_WAIT, S_PV_MUL, S_PV_WAIT, S_SQ_MUL, S_SQ_WAIT,
        S_SQ_INIT, S_SQRT, S_R_CHK, S_R2_MUL, S_R2_WAIT, S_R3_MUL, S_R3_WAIT,
        S_AC_CHK, S_AC_MUL, S_AC_WAIT, S_DIV_CHK, S_DIV, S_DV_MUL, S_DV_WAIT,
        S_FIN_POS, S_DONE
    } state_t;

    function automatic logic [MAG_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] n;
        n = WORD_BITS'(-v);
        return v[WORD_BITS-1] ? {{(MAG_BITS-WORD_BITS){1'b0}}, n}
                              : {{(MAG_BITS-WORD_BITS){1'b0}}, v};
    endfunction

    function automatic word_sat_t pack_word(input logic neg, input logic [MAG_BITS-1:0] mag);
        word_sat_t            r;
        logic [MAG_BITS-1:0]  lim;
        logic [MAG_BITS-1:0]  m;
        lim   = neg ? HALF_WORD : HALF_WORD - 64'd1;
        r.sat = mag > lim;
        m     = r.sat ? lim : mag;
        r.word = neg ? WORD_BITS'(-m[WORD_BITS-1:0]) : m[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic word_sat_t sadd(input logic an, input logic [MAG_BITS-1:0] am,
                                       input logic bn, input logic [MAG_BITS-1:0] bm);
        word_sat_t           r;
        logic [MAG_BITS:0]   s;
        logic [MAG_BITS-1:0] m;
        s = {1'b0, am} + {1'b0, bm};
        m = s[MAG_BITS] ? '1 : s[MAG_BITS-1:0];
        if (an == bn)
        begin
            r = pack_word(an, m);
            r.sat = r.sat | s[MAG_BITS];
        end
        else if (am >= bm)
        begin
            r = pack_word(an, am - bm);
        end
        else
        begin
            r = pack_word(bn, bm - am);
        end
        return r;
    endfunction

endpackage

FILE: rtl/ecgos_qmul.sv
// Shared multiplier: 64x64 product from four 32x32 partial products.
// Also rounds the product back to Q.FRAC_BITS with clamping to 64 bits.
// Depends on ecgos_pkg.
`timescale 1ns / 1ps

module ecgos_qmul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ecgos_pkg::MAG_BITS-1:0] a,
    input  logic [ecgos_pkg::MAG_BITS-1:0] b,
    output logic                           done,
    output logic [2*ecgos_pkg::MAG_BITS-1:0] prod,
    output logic [ecgos_pkg::MAG_BITS-1:0] q,
    output logic                           ovf
);

    localparam int M = ecgos_pkg::MAG_BITS;
    localparam int H = M / 2;
    localparam int F = ecgos_pkg::FRAC_BITS;
    localparam logic [2:0] STEP_IDLE  = 3'd0;
    localparam logic [2:0] STEP_FIRST = 3'd1;
    localparam logic [2:0] STEP_LAST  = 3'd4;
    localparam logic [2:0] STEP_ROUND = 3'd5;

    logic [2:0]     step_reg;
    logic [M-1:0]   a_reg;
    logic [M-1:0]   b_reg;
    logic [2*M-1:0] acc_reg;
    logic [M-1:0]   q_reg;
    logic           ovf_reg;
    logic           done_reg;

    logic [1:0]     k;
    logic [H-1:0]   ah;
    logic [H-1:0]   bh;
    logic [M-1:0]   pp;
    logic [2*M-1:0] pp_sh;
    logic [2*M-1:0] rnd;

    always_comb
    begin
        k  = 2'(step_reg - STEP_FIRST);
        ah = k[1] ? a_reg[M-1:H] : a_reg[H-1:0];
        bh = k[0] ? b_reg[M-1:H] : b_reg[H-1:0];
        pp = M'(ah) * M'(bh);
        unique case (k)
            2'd0:    pp_sh = {{M{1'b0}}, pp};
            2'd3:    pp_sh = {pp, {M{1'b0}}};
            default: pp_sh = {{H{1'b0}}, pp, {H{1'b0}}};
        endcase
        rnd = acc_reg + ((2*M)'(1) << (F - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= STEP_FIRST;
            end
            else if (step_reg >= STEP_FIRST && step_reg <= STEP_LAST)
            begin
                step_reg <= step_reg + 3'd1;
            end
            else if (step_reg == STEP_ROUND)
            begin
                step_reg <= STEP_IDLE;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (step_reg >= STEP_FIRST && step_reg <= STEP_LAST)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
        else if (step_reg == STEP_ROUND)
        begin
            ovf_reg <= |rnd[2*M-1:M+F];
            q_reg   <= (|rnd[2*M-1:M+F]) ? '1 : rnd[M+F-1:F];
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
    assign q    = q_reg;
    assign ovf  = ovf_reg;

endmodule

FILE: rtl/euler_central_gravity_orbit_step_core.sv
// Top level of the Euler central-gravity orbit step core.
// Holds the body state, the sequencer, square root and divider steps.
// Depends on ecgos_pkg and ecgos_qmul.
`timescale 1ns / 1ps

// One body's position and velocity, advanced by forward Euler under central
// gravity in signed Q24.32. A step item finishes sooner when the radius is
// zero or a coordinate is zero. The time is set by the shared multiplier,
// which forms each product from four 32x32 partial products and a rounding
// step, and by the square root and the division per coordinate, each
// retiring one bit a cycle. The core takes one item at a time; in_stall is
// high from acceptance until the result is registered, and a result waiting
// on out_stall does not block the next item.
module euler_central_gravity_orbit_step_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  ecgos_pkg::in_item_t                   in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output ecgos_pkg::out_item_t                  out_item,
    input  logic                                  cfg_en,
    input  logic [ecgos_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [ecgos_pkg::REG_BITS-1:0]        cfg_data
);

    localparam int W = ecgos_pkg::WORD_BITS;
    localparam int M = ecgos_pkg::MAG_BITS;
    localparam int F = ecgos_pkg::FRAC_BITS;
    localparam int R = ecgos_pkg::REG_BITS;
    localparam logic [1:0] LAST_IDX = 2'd2;
    localparam logic [5:0] LAST_BIT = 6'd63;

    ecgos_pkg::state_t    state_reg, state_next;
    ecgos_pkg::in_item_t  in_reg;
    ecgos_pkg::out_item_t out_reg;
    logic                 out_valid_reg;

    logic [R-1:0]   g_reg;
    logic [R-1:0]   h_reg;
    logic [W-1:0]   position_reg [3];
    logic [W-1:0]   velocity_reg [3];
    logic [W-1:0]   np_reg [3];
    logic [1:0]     idx_reg;
    logic [5:0]     cnt_reg;
    logic           sat_reg;
    logic           origin_reg;
    logic [M-1:0]   s_reg;
    logic [2*M-1:0] rad_reg;
    logic [M+1:0]   rem_reg;
    logic [M-1:0]   root_reg;
    logic [M-1:0]   r2_reg;
    logic [M-1:0]   r3_reg;
    logic [2*M-1:0] num_reg;
    logic [M-1:0]   drem_reg;
    logic [M-1:0]   dlo_reg;
    logic [M-1:0]   acc_reg;

    logic           mul_start;
    logic [M-1:0]   mul_a;
    logic [M-1:0]   mul_b;
    logic           mul_done;
    logic [2*M-1:0] mul_prod;
    logic [M-1:0]   mul_q;
    logic           mul_ovf;

    logic [W-1:0]   pos_c;
    logic [W-1:0]   vel_c;
    logic [M-1:0]   pm;
    logic [M-1:0]   vm;
    logic           pn;
    logic           vn;
    logic [W-1:0]   ld_pos;
    logic [W-1:0]   ld_vel;
    ecgos_pkg::word_sat_t ld_pack;
    ecgos_pkg::word_sat_t pv_sum;
    ecgos_pkg::word_sat_t dv_sum;
    logic [M:0]     s_sum;
    logic [M+3:0]   sq_rem;
    logic [M+3:0]   sq_try;
    logic           sq_ge;
    logic [M:0]     dv_shift;
    logic           dv_ge;
    logic           last_idx;
    logic           out_go;

    ecgos_qmul u_qmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod),
        .q     (mul_q),
        .ovf   (mul_ovf)
    );

    always_comb
    begin
        pos_c = position_reg[idx_reg];
        vel_c = velocity_reg[idx_reg];
        pm    = ecgos_pkg::mag_of(pos_c);
        vm    = ecgos_pkg::mag_of(vel_c);
        pn    = pos_c[W-1];
        vn    = vel_c[W-1];
        unique case (idx_reg)
            2'd0:
            begin
                ld_pos = in_reg.init_pos_x;
                ld_vel = in_reg.init_vel_x;
            end
            2'd1:
            begin
                ld_pos = in_reg.init_pos_y;
                ld_vel = in_reg.init_vel_y;
            end
            default:
            begin
                ld_pos = in_reg.init_pos_z;
                ld_vel = in_reg.init_vel_z;
            end
        endcase
        ld_pack  = ecgos_pkg::pack_word(ld_vel[W-1], mul_q);
        pv_sum   = ecgos_pkg::sadd(pn, pm, vn, mul_q);
        dv_sum   = ecgos_pkg::sadd(vn, vm, !pn, mul_q);
        s_sum    = {1'b0, s_reg} + {1'b0, mul_q};
        sq_rem   = {rem_reg, rad_reg[2*M-1:2*M-2]};
        sq_try   = {2'b00, root_reg, 2'b01};
        sq_ge    = sq_rem >= sq_try;
        dv_shift = {drem_reg, dlo_reg[M-1]};
        dv_ge    = dv_shift >= {1'b0, r3_reg};
        last_idx = idx_reg == LAST_IDX;
        out_go   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = pm;
        mul_b      = pm;
        unique case (state_reg)
            ecgos_pkg::S_IDLE:
                if (in_valid)
                    state_next = (in_item.action == ecgos_pkg::ACT_LOAD)
                               ? ecgos_pkg::S_LD_MUL : ecgos_pkg::S_PV_MUL;
            ecgos_pkg::S_LD_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = ecgos_pkg::mag_of(ld_vel);
                mul_b      = ecgos_pkg::VEL_SCALE;
                state_next = ecgos_pkg::S_LD_WAIT;
            end
            ecgos_pkg::S_LD_WAIT:
                if (mul_done)
                    state_next = last_idx ? ecgos_pkg::S_DONE : ecgos_pkg::S_LD_MUL;
            ecgos_pkg::S_PV_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = vm;
                mul_b      = {{(M-R){1'b0}}, h_reg};
                state_next = ecgos_pkg::S_PV_WAIT;
            end
            ecgos_pkg::S_PV_WAIT:
                if (mul_done)
                    state_next = last_idx ? ecgos_pkg::S_SQ_MUL : ecgos_pkg::S_PV_MUL;
            ecgos_pkg::S_SQ_MUL:
            begin
                mul_start  = 1'b1;
                state_next = ecgos_pkg::S_SQ_WAIT;
            end
            ecgos_pkg::S_SQ_WAIT:
                if (mul_done)
                    state_next = last_idx ? ecgos_pkg::S_SQ_INIT : ecgos_pkg::S_SQ_MUL;
            ecgos_pkg::S_SQ_INIT:
                state_next = ecgos_pkg::S_SQRT;
            ecgos_pkg::S_SQRT:
                if (cnt_reg == '0)
                    state_next = ecgos_pkg::S_R_CHK;
            ecgos_pkg::S_R_CHK:
                state_next = (root_reg == '0) ? ecgos_pkg::S_FIN_POS : ecgos_pkg::S_R2_MUL;
            ecgos_pkg::S_R2_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = root_reg;
                mul_b      = root_reg;
                state_next = ecgos_pkg::S_R2_WAIT;
            end
            ecgos_pkg::S_R2_WAIT:
                if (mul_done)
                    state_next = ecgos_pkg::S_R3_MUL;
            ecgos_pkg::S_R3_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = r2_reg;
                mul_b      = root_reg;
                state_next = ecgos_pkg::S_R3_WAIT;
            end
            ecgos_pkg::S_R3_WAIT:
                if (mul_done)
                    state_next = ecgos_pkg::S_AC_CHK;
            ecgos_pkg::S_AC_CHK:
                state_next = (pm == '0 || r3_reg == '0)
                           ? ecgos_pkg::S_DV_MUL : ecgos_pkg::S_AC_MUL;
            ecgos_pkg::S_AC_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = {{(M-R){1'b0}}, g_reg};
                mul_b      = pm;
                state_next = ecgos_pkg::S_AC_WAIT;
            end
            ecgos_pkg::S_AC_WAIT:
                if (mul_done)
                    state_next = ecgos_pkg::S_DIV_CHK;
            ecgos_pkg::S_DIV_CHK:
                state_next = (num_reg[2*M-1:M] >= r3_reg)
                           ? ecgos_pkg::S_DV_MUL : ecgos_pkg::S_DIV;
            ecgos_pkg::S_DIV:
                if (cnt_reg == '0)
                    state_next = ecgos_pkg::S_DV_MUL;
            ecgos_pkg::S_DV_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = acc_reg;
                mul_b      = {{(M-R){1'b0}}, h_reg};
                state_next = ecgos_pkg::S_DV_WAIT;
            end
            ecgos_pkg::S_DV_WAIT:
                if (mul_done)
                    state_next = last_idx ? ecgos_pkg::S_FIN_POS : ecgos_pkg::S_AC_CHK;
            ecgos_pkg::S_FIN_POS:
                state_next = ecgos_pkg::S_DONE;
            ecgos_pkg::S_DONE:
                if (out_go)
                    state_next = ecgos_pkg::S_IDLE;
            default:
                state_next = ecgos_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecgos_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration, body state, output valid and coordinate index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg         <= ecgos_pkg::G_RESET;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                position_reg[i] <= '0;
                velocity_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_en && cfg_index == ecgos_pkg::REG_GRAVITY)
                g_reg <= cfg_data;
            if (cfg_en && cfg_index == ecgos_pkg::REG_STEP)
                h_reg <= cfg_data;

            if (state_reg == ecgos_pkg::S_DONE && out_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ecgos_pkg::S_IDLE:
                    idx_reg <= '0;
                ecgos_pkg::S_LD_WAIT:
                    if (mul_done)
                    begin
                        position_reg[idx_reg] <= ld_pos;
                        velocity_reg[idx_reg] <= ld_pack.word;
                        idx_reg <= last_idx ? 2'd0 : idx_reg + 2'd1;
                    end
                ecgos_pkg::S_PV_WAIT, ecgos_pkg::S_SQ_WAIT:
                    if (mul_done)
                        idx_reg <= last_idx ? 2'd0 : idx_reg + 2'd1;
                ecgos_pkg::S_DV_WAIT:
                    if (mul_done)
                    begin
                        velocity_reg[idx_reg] <= dv_sum.word;
                        idx_reg <= last_idx ? 2'd0 : idx_reg + 2'd1;
                    end
                ecgos_pkg::S_FIN_POS:
                    for (int i = 0; i < 3; i++)
                        position_reg[i] <= np_reg[i];
                default:
                    idx_reg <= idx_reg;
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ecgos_pkg::S_IDLE:
                if (in_valid)
                begin
                    in_reg     <= in_item;
                    sat_reg    <= 1'b0;
                    origin_reg <= 1'b0;
                    s_reg      <= '0;
                end
            ecgos_pkg::S_LD_WAIT:
                if (mul_done)
                    sat_reg <= sat_reg | mul_ovf | ld_pack.sat;
            ecgos_pkg::S_PV_WAIT:
                if (mul_done)
                begin
                    np_reg[idx_reg] <= pv_sum.word;
                    sat_reg <= sat_reg | mul_ovf | pv_sum.sat;
                end
            ecgos_pkg::S_SQ_WAIT:
                if (mul_done)
                begin
                    s_reg   <= s_sum[M] ? '1 : s_sum[M-1:0];
                    sat_reg <= sat_reg | mul_ovf | s_sum[M];
                end
            ecgos_pkg::S_SQ_INIT:
            begin
                rad_reg  <= {{(M-F){1'b0}}, s_reg, {F{1'b0}}};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= LAST_BIT;
            end
            ecgos_pkg::S_SQRT:
            begin
                rad_reg <= {rad_reg[2*M-3:0], 2'b00};
                if (sq_ge)
                begin
                    rem_reg  <= (M+2)'(sq_rem - sq_try);
                    root_reg <= {root_reg[M-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_rem[M+1:0];
                    root_reg <= {root_reg[M-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
            ecgos_pkg::S_R_CHK:
                if (root_reg == '0)
                    origin_reg <= 1'b1;
            ecgos_pkg::S_R2_WAIT:
                if (mul_done)
                begin
                    r2_reg  <= mul_q;
                    sat_reg <= sat_reg | mul_ovf;
                end
            ecgos_pkg::S_R3_WAIT:
                if (mul_done)
                begin
                    r3_reg  <= mul_q;
                    sat_reg <= sat_reg | mul_ovf;
                end
            ecgos_pkg::S_AC_CHK:
                if (pm == '0)
                    acc_reg <= '0;
                else if (r3_reg == '0)
                begin
                    acc_reg <= '1;
                    sat_reg <= 1'b1;
                end
            ecgos_pkg::S_AC_WAIT:
                if (mul_done)
                    num_reg <= mul_prod + {{(M+1){1'b0}}, r3_reg[M-1:1]};
            ecgos_pkg::S_DIV_CHK:
                if (num_reg[2*M-1:M] >= r3_reg)
                begin
                    acc_reg <= '1;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    drem_reg <= num_reg[2*M-1:M];
                    dlo_reg  <= num_reg[M-1:0];
                    cnt_reg  <= LAST_BIT;
                end
            ecgos_pkg::S_DIV:
            begin
                dlo_reg  <= {dlo_reg[M-2:0], 1'b0};
                drem_reg <= dv_ge ? M'(dv_shift - {1'b0, r3_reg}) : dv_shift[M-1:0];
                acc_reg  <= {acc_reg[M-2:0], dv_ge};
                cnt_reg  <= cnt_reg - 6'd1;
            end
            ecgos_pkg::S_DV_WAIT:
                if (mul_done)
                    sat_reg <= sat_reg | mul_ovf | dv_sum.sat;
            ecgos_pkg::S_DONE:
                if (out_go)
                begin
                    out_reg.pos_x     <= position_reg[0];
                    out_reg.pos_y     <= position_reg[1];
                    out_reg.pos_z     <= position_reg[2];
                    out_reg.vel_x     <= velocity_reg[0];
                    out_reg.vel_y     <= velocity_reg[1];
                    out_reg.vel_z     <= velocity_reg[2];
                    out_reg.at_origin <= origin_reg;
                    out_reg.saturated <= sat_reg;
                end
            default:
            begin
            end
        endcase
    end

    assign in_stall  = state_reg != ecgos_pkg::S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != ecgos_pkg::S_IDLE)
        else $error("accepted item did not start the sequencer");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ecgos_pkg::S_DIV |-> drem_reg < r3_reg)
        else $error("division remainder not below divisor");

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ecgos_pkg::S_SQRT |-> rem_reg <= {1'b0, root_reg, 1'b0})
        else $error("square root remainder out of range");

    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |=> !mul_done)
        else $error("multiplier done too early");

endmodule

FILE: bench/tb_euler_central_gravity_orbit_step_core.sv
// Testbench for euler_central_gravity_orbit_step_core: directed table, then random load/step runs.
// A bit-exact predictor or a typed row's want checks each result; needs ecgos_pkg and the core.
`timescale 1ns / 1ps

module tb_euler_central_gravity_orbit_step_core;

    localparam int WORD_BITS = ecgos_pkg::WORD_BITS;
    localparam int FRAC_BITS = ecgos_pkg::FRAC_BITS;
    localparam int IDX_BITS  = ecgos_pkg::IDX_BITS;
    localparam int REG_BITS  = ecgos_pkg::REG_BITS;

    typedef ecgos_pkg::in_item_t  in_item_t;
    typedef ecgos_pkg::out_item_t out_item_t;

    localparam logic ACT_STEP = 1'b1;
    localparam logic [IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_SPARE_B = 2'd3;
    localparam int RANDOM_ITEMS = 1080;
    localparam int PHASES = 5;
    localparam int HOLD_CYCLES = 3000;
    localparam int STALL_LIMIT = 20000;
    localparam logic [63:0] ALL_ONES = '1;
    localparam logic [REG_BITS-1:0] REG_MAX = '1;

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;
    logic cfg_en;
    logic [IDX_BITS-1:0] cfg_index;
    logic [REG_BITS-1:0] cfg_data;

    logic [WORD_BITS-1:0] body_pos[3];
    logic [WORD_BITS-1:0] body_vel[3];
    logic [REG_BITS-1:0] grav_g;
    logic [REG_BITS-1:0] step_h;

    out_item_t pending_states[$];
    row_t rows[$];
    int errors;
    int n_loads, n_steps, n_origin, n_sat, n_results;
    int hold_len;
    bit idle_on;
    int quiet;

    euler_central_gravity_orbit_step_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b,
                                           inout logic sat);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b} + (128'd1 << (FRAC_BITS - 1));
        if (p[127:96] != 0)
        begin
            sat = 1'b1;
            return ALL_ONES;
        end
        return p[95:32];
    endfunction

    function automatic logic [63:0] magnitude(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] n;
        n = -v;
        return v[WORD_BITS-1] ? {8'd0, n} : {8'd0, v};
    endfunction

    function automatic logic [WORD_BITS-1:0] clamp_word(input logic neg, input logic [63:0] mag,
                                                        inout logic sat);
        logic [63:0] lim;
        logic [63:0] m;
        lim = neg ? (64'd1 << (WORD_BITS - 1)) : (64'd1 << (WORD_BITS - 1)) - 64'd1;
        m = mag;
        if (m > lim)
        begin
            m = lim;
            sat = 1'b1;
        end
        return neg ? WORD_BITS'(-m) : m[WORD_BITS-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] signed_sum(input logic an, input logic [63:0] am,
                                                        input logic bn, input logic [63:0] bm,
                                                        inout logic sat);
        logic [64:0] s;
        if (an == bn)
        begin
            s = {1'b0, am} + {1'b0, bm};
            if (s[64])
            begin
                sat = 1'b1;
                s[63:0] = ALL_ONES;
            end
            return clamp_word(an, s[63:0], sat);
        end
        if (am >= bm)
            return clamp_word(an, am - bm, sat);
        return clamp_word(bn, bm - am, sat);
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] x);
        logic [63:0] root;
        logic [63:0] t;
        root = 0;
        for (int i = 63; i >= 0; i--)
        begin
            t = root | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= x)
                root = t;
        end
        return root;
    endfunction

    function automatic out_item_t advance_body(input in_item_t it);
        out_item_t o;
        logic sat;
        logic origin;
        logic pn[3];
        logic vn[3];
        logic [63:0] pm[3];
        logic [63:0] vm[3];
        logic [WORD_BITS-1:0] np[3];
        logic [WORD_BITS-1:0] raw[6];
        logic [63:0] s;
        logic [64:0] t;
        logic [63:0] r;
        logic [63:0] r3;
        logic [63:0] acc;
        logic [63:0] q;
        logic [127:0] num;
        sat = 1'b0;
        origin = 1'b0;
        raw[0] = it.init_pos_x;
        raw[1] = it.init_pos_y;
        raw[2] = it.init_pos_z;
        raw[3] = it.init_vel_x;
        raw[4] = it.init_vel_y;
        raw[5] = it.init_vel_z;
        if (it.action == ecgos_pkg::ACT_LOAD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                body_pos[i] = raw[i];
                q = fx_mul(magnitude(raw[3+i]), ecgos_pkg::VEL_SCALE, sat);
                body_vel[i] = clamp_word(raw[3+i][WORD_BITS-1], q, sat);
            end
        end
        else
        begin
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                pn[i] = body_pos[i][WORD_BITS-1];
                pm[i] = magnitude(body_pos[i]);
                vn[i] = body_vel[i][WORD_BITS-1];
                vm[i] = magnitude(body_vel[i]);
                q = fx_mul(vm[i], 64'(step_h), sat);
                np[i] = signed_sum(pn[i], pm[i], vn[i], q, sat);
                q = fx_mul(pm[i], pm[i], sat);
                t = {1'b0, s} + {1'b0, q};
                if (t[64])
                begin
                    sat = 1'b1;
                    t[63:0] = ALL_ONES;
                end
                s = t[63:0];
            end
            r = root_floor({64'd0, s} << FRAC_BITS);
            if (r == 0)
                origin = 1'b1;
            else
            begin
                q = fx_mul(r, r, sat);
                r3 = fx_mul(q, r, sat);
                for (int i = 0; i < 3; i++)
                begin
                    if (pm[i] == 0)
                        acc = 0;
                    else if (r3 == 0)
                    begin
                        acc = ALL_ONES;
                        sat = 1'b1;
                    end
                    else
                    begin
                        num = {64'd0, 64'(grav_g)} * {64'd0, pm[i]} + {64'd0, r3 >> 1};
                        if (num[127:64] >= r3)
                        begin
                            acc = ALL_ONES;
                            sat = 1'b1;
                        end
                        else
                            acc = 64'(num / {64'd0, r3});
                    end
                    q = fx_mul(acc, 64'(step_h), sat);
                    body_vel[i] = signed_sum(vn[i], vm[i], !pn[i], q, sat);
                end
            end
            for (int i = 0; i < 3; i++)
                body_pos[i] = np[i];
        end
        o.pos_x = body_pos[0];
        o.pos_y = body_pos[1];
        o.pos_z = body_pos[2];
        o.vel_x = body_vel[0];
        o.vel_y = body_vel[1];
        o.vel_z = body_vel[2];
        o.at_origin = origin;
        o.saturated = sat;
        return o;
    endfunction

    task automatic report(input string field, input logic [WORD_BITS-1:0] got,
                          input logic [WORD_BITS-1:0] want);
        errors++;
        $display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_states.size() == 0)
                report("unexpected item", '0, '0);
            else
            begin
                out_item_t w;
                w = pending_states.pop_front();
                if (out_item.pos_x !== w.pos_x) report("pos_x", out_item.pos_x, w.pos_x);
                if (out_item.pos_y !== w.pos_y) report("pos_y", out_item.pos_y, w.pos_y);
                if (out_item.pos_z !== w.pos_z) report("pos_z", out_item.pos_z, w.pos_z);
                if (out_item.vel_x !== w.vel_x) report("vel_x", out_item.vel_x, w.vel_x);
                if (out_item.vel_y !== w.vel_y) report("vel_y", out_item.vel_y, w.vel_y);
                if (out_item.vel_z !== w.vel_z) report("vel_z", out_item.vel_z, w.vel_z);
                if (out_item.at_origin !== w.at_origin)
                    report("at_origin", WORD_BITS'(out_item.at_origin), WORD_BITS'(w.at_origin));
                if (out_item.saturated !== w.saturated)
                    report("saturated", WORD_BITS'(out_item.saturated), WORD_BITS'(w.saturated));
                n_origin += int'(w.at_origin);
                n_sat += int'(w.saturated);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        out_stall = 1'b1;
        wait (rst_n);
        forever
        begin
            if (hold_len > 0)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (hold_len) @(negedge clk);
                hold_len = 0;
            end
            n = idle_on ? $urandom_range(0, 3) : 0;
            @(negedge clk);
            out_stall = (n != 0);
            if (n != 0)
            begin
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
        @(negedge clk);
        cfg_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == ecgos_pkg::REG_GRAVITY)
            grav_g = val;
        else if (idx == ecgos_pkg::REG_STEP)
            step_h = val;
        @(negedge clk);
        cfg_en = 1'b0;
    endtask

    task automatic send(input row_t rw);
        int gap;
        out_item_t p;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = rw.it;
        do @(posedge clk); while (in_stall);
        p = advance_body(rw.it);
        pending_states.push_back(rw.typed ? rw.want : p);
        if (rw.it.action == ecgos_pkg::ACT_LOAD)
            n_loads++;
        else
            n_steps++;
        @(negedge clk);
    endtask

    function automatic in_item_t make_item(input logic act,
                                           input logic [WORD_BITS-1:0] px,
                                           input logic [WORD_BITS-1:0] py,
                                           input logic [WORD_BITS-1:0] pz,
                                           input logic [WORD_BITS-1:0] vx,
                                           input logic [WORD_BITS-1:0] vy,
                                           input logic [WORD_BITS-1:0] vz);
        in_item_t it;
        it.action = act;
        it.init_pos_x = px;
        it.init_pos_y = py;
        it.init_pos_z = pz;
        it.init_vel_x = vx;
        it.init_vel_y = vy;
        it.init_vel_z = vz;
        return it;
    endfunction

    function automatic row_t free_row(input in_item_t it);
        row_t rw;
        rw.it = it;
        rw.typed = 1'b0;
        rw.want = '0;
        return rw;
    endfunction

    function automatic row_t typed_row(input in_item_t it, input logic [WORD_BITS-1:0] p,
                                       input logic [WORD_BITS-1:0] v,
                                       input logic org, input logic sat);
        row_t rw;
        rw.it = it;
        rw.typed = 1'b1;
        rw.want = {p, p, p, v, v, v, org, sat};
        return rw;
    endfunction

    function automatic logic [WORD_BITS-1:0] any_word();
        return WORD_BITS'({$urandom, $urandom});
    endfunction

    function automatic logic [WORD_BITS-1:0] scaled_word(input int lo, input int hi);
        logic [WORD_BITS-1:0] m;
        m = any_word() >> $urandom_range(lo, hi);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic in_item_t random_item();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            return make_item(1'($urandom), any_word(), any_word(), any_word(),
                             any_word(), any_word(), any_word());
        if (kind <= 2)
            return make_item(ecgos_pkg::ACT_LOAD, scaled_word(16, 40), scaled_word(16, 40),
                             scaled_word(16, 54), scaled_word(24, 54), scaled_word(24, 54),
                             scaled_word(24, 54));
        return make_item(ACT_STEP, any_word(), any_word(), any_word(),
                         any_word(), any_word(), any_word());
    endfunction

    initial
    begin
        logic [WORD_BITS-1:0] pmax;
        logic [WORD_BITS-1:0] pmin;
        logic [REG_BITS-1:0] g_set[PHASES];
        logic [REG_BITS-1:0] h_set[PHASES];
        pmax = {1'b0, {(WORD_BITS-1){1'b1}}};
        pmin = {1'b1, {(WORD_BITS-1){1'b0}}};
        errors = 0;
        n_loads = 0;
        n_steps = 0;
        n_origin = 0;
        n_sat = 0;
        n_results = 0;
        hold_len = 0;
        idle_on = 1'b1;
        quiet = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_en = 1'b0;
        cfg_index = ecgos_pkg::REG_GRAVITY;
        cfg_data = '0;
        grav_g = ecgos_pkg::G_RESET;
        step_h = '0;
        for (int i = 0; i < 3; i++)
        begin
            body_pos[i] = '0;
            body_vel[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        rows.push_back(typed_row(make_item(ACT_STEP, pmax, pmin, 1, 2, 3, 4), 0, 0, 1, 0));
        rows.push_back(typed_row(make_item(ecgos_pkg::ACT_LOAD, 0, 0, 0, 0, 0, 0),
                                 0, 0, 0, 0));
        rows.push_back(typed_row(make_item(ecgos_pkg::ACT_LOAD, pmax, pmax, pmax,
                                           pmax, pmax, pmax), pmax, pmax, 0, 1));
        rows.push_back(typed_row(make_item(ecgos_pkg::ACT_LOAD, pmin, pmin, pmin,
                                           pmin, pmin, pmin), pmin, pmin, 0, 1));
        rows.push_back(free_row(make_item(ACT_STEP, 0, 0, 0, 0, 0, 0)));
        rows.push_back(free_row(make_item(ecgos_pkg::ACT_LOAD, pmax, pmin, pmax, 0, 0, 0)));
        rows.push_back(free_row(make_item(ACT_STEP, 0, 0, 0, 0, 0, 0)));
        rows.push_back(free_row(make_item(ecgos_pkg::ACT_LOAD, 46341, 0, 0, 0, 0, 0)));
        rows.push_back(free_row(make_item(ACT_STEP, 0, 0, 0, 0, 0, 0)));
        rows.push_back(free_row(make_item(ecgos_pkg::ACT_LOAD, 0, 0, 0, 56'd1 << 30,
                                          -(56'd1 << 29), 56'd1 << 28)));
        rows.push_back(free_row(make_item(ACT_STEP, 0, 0, 0, 0, 0, 0)));
        rows.push_back(free_row(make_item(ACT_STEP, 0, 0, 0, 0, 0, 0)));
        rows.push_back(free_row(make_item(ecgos_pkg::ACT_LOAD, 56'd1 << 32, 0, 0, 0,
                                          56'd1 << 24, 0)));
        for (int i = 0; i < 5; i++)
            rows.push_back(free_row(make_item(ACT_STEP, 0, 0, 0, 0, 0, 0)));
        rows.push_back(free_row(make_item(ecgos_pkg::ACT_LOAD, -(56'd3 << 40), 56'd5 << 38, 0,
                                          pmin, 1, -1)));
        rows.push_back(free_row(make_item(ACT_STEP, 0, 0, 0, 0, 0, 0)));

        write_reg(ecgos_pkg::REG_STEP, REG_SPARE_A == REG_SPARE_B ? 0 : 55'd1 << 22);
        write_reg(REG_SPARE_A, REG_MAX);
        write_reg(REG_SPARE_B, 55'h1234_5678_9abc);
        foreach (rows[i])
            send(rows[i]);
        in_valid = 1'b0;

        g_set[0] = ecgos_pkg::G_RESET; h_set[0] = 55'd1 << 22;
        g_set[1] = 0;           h_set[1] = 55'd1 << 28;
        g_set[2] = REG_MAX;     h_set[2] = REG_MAX;
        g_set[3] = REG_BITS'({$urandom, $urandom}); h_set[3] = 0;
        g_set[4] = REG_BITS'({$urandom, $urandom}) >> 10;
        h_set[4] = REG_BITS'($urandom) >> 4;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait (pending_states.size() == 0);
            repeat (10) @(posedge clk);
            write_reg(ecgos_pkg::REG_GRAVITY, g_set[ph]);
            write_reg(ecgos_pkg::REG_STEP, h_set[ph]);
            if (ph == 1)
                hold_len = HOLD_CYCLES;
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++)
            begin
                idle_on = ((k / 64) % 3) != 2;
                send(free_row(random_item()));
            end
            in_valid = 1'b0;
            idle_on = 1'b1;
        end

        wait (pending_states.size() == 0);
        repeat (400) @(posedge clk);
        $display("covered %0d loads and %0d steps over %0d register settings",
                 n_loads, n_steps, PHASES + 1);
        $display("%0d results checked, %0d at origin, %0d saturated, %0d mismatches",
                 n_results, n_origin, n_sat, errors);
        if (errors == 0 && pending_states.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
